### sv/dis_pkg.sv
// Shared types and constants of the diagonal index set generator.
// Used by every module of the block but dis_cell; depends on nothing.
`default_nettype none
package dis_pkg;

   // Widths fixed by the word formats.
   localparam int unsigned POS_W  = 24;   // item position
   localparam int unsigned REG_W  = 13;   // one dimension register
   localparam int unsigned MOD_W  = 26;   // n*m and all residues mod n*m
   localparam int unsigned COEF_W = 14;   // signed Bezout coefficient
   localparam int unsigned SIZE_W = 9;    // reported set size
   localparam int unsigned IDX_W  = 2;    // register index
   localparam int unsigned STEP_W = 2;    // sub-step of a four-step phase

   // Register indexes.
   localparam logic [IDX_W-1:0] REG_ROWS_TOTAL = 2'd0;
   localparam logic [IDX_W-1:0] REG_COLS_TOTAL = 2'd1;
   localparam logic [IDX_W-1:0] REG_SUB_ROWS   = 2'd2;
   localparam logic [IDX_W-1:0] REG_SUB_COLS   = 2'd3;

   // Sub-steps, used by the reduction, term and multiply phases.
   localparam logic [STEP_W-1:0] STEP_FIRST  = 2'd0;
   localparam logic [STEP_W-1:0] STEP_SECOND = 2'd1;
   localparam logic [STEP_W-1:0] STEP_THIRD  = 2'd2;
   localparam logic [STEP_W-1:0] STEP_LAST   = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_GCD,
      ST_GCD_WAIT,
      ST_PRE,
      ST_PRE_WAIT,
      ST_DIV,
      ST_DIV_WAIT,
      ST_MUL,
      ST_MUL_WAIT,
      ST_SUM,
      ST_SEARCH,
      ST_INSERT,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

### sv/dis_cell.sv
// One storage cell of the index chain: holds one stored index and passes it on.
// Depends on nothing.
`default_nettype none
module dis_cell #(
   parameter int unsigned WIDTH = 24
) (
   input  wire logic             clock,
   input  wire logic             shift_en,
   input  wire logic [WIDTH-1:0] d,
   output logic      [WIDTH-1:0] q
);
   logic [WIDTH-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         value_ff <= d;
      end
   end

   assign q = value_ff;
endmodule
`default_nettype wire

### sv/dis_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on dis_pkg.
`default_nettype none
module dis_divider (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [dis_pkg::MOD_W-1:0] dividend,
   input  wire logic [dis_pkg::MOD_W-1:0] divisor,
   output logic                           done,
   output logic [dis_pkg::MOD_W-1:0]      quotient,
   output logic [dis_pkg::MOD_W-1:0]      remainder
);
   localparam int unsigned CW = $clog2(dis_pkg::MOD_W + 1);

   logic                      busy_ff;
   logic                      done_ff;
   logic [CW-1:0]             cnt_ff;
   logic [dis_pkg::MOD_W-1:0] quo_ff;
   logic [dis_pkg::MOD_W:0]   rem_ff;
   logic [dis_pkg::MOD_W-1:0] den_ff;
   logic [dis_pkg::MOD_W:0]   trial;
   logic [dis_pkg::MOD_W:0]   diff;

   assign trial = {rem_ff[dis_pkg::MOD_W-1:0], quo_ff[dis_pkg::MOD_W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(dis_pkg::MOD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // The quotient register doubles as the dividend shifter.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff[dis_pkg::MOD_W]) begin
            rem_ff <= diff;
            quo_ff <= {quo_ff[dis_pkg::MOD_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[dis_pkg::MOD_W-2:0], 1'b0};
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[dis_pkg::MOD_W-1:0];
endmodule
`default_nettype wire

### sv/dis_modmul.sv
// Bit-serial modular multiplier: product of two residues modulo a modulus.
// Depends on dis_pkg.
`default_nettype none
module dis_modmul (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [dis_pkg::MOD_W-1:0] op_a,
   input  wire logic [dis_pkg::MOD_W-1:0] op_b,
   input  wire logic [dis_pkg::MOD_W-1:0] modulus,
   output logic                           done,
   output logic [dis_pkg::MOD_W-1:0]      product
);
   localparam int unsigned CW = $clog2(dis_pkg::MOD_W + 1);

   logic                      busy_ff;
   logic                      done_ff;
   logic [CW-1:0]             cnt_ff;
   logic [dis_pkg::MOD_W-1:0] a_ff;
   logic [dis_pkg::MOD_W-1:0] b_ff;
   logic [dis_pkg::MOD_W-1:0] mod_ff;
   logic [dis_pkg::MOD_W-1:0] acc_ff;
   logic [dis_pkg::MOD_W:0]   dbl;
   logic [dis_pkg::MOD_W:0]   dbl_red;
   logic [dis_pkg::MOD_W:0]   add;
   logic [dis_pkg::MOD_W:0]   acc_in;

   // Horner step: acc = 2*acc (+ b) mod modulus, top bit of a first.
   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, mod_ff}) ? dbl - {1'b0, mod_ff} : dbl;
      add     = a_ff[dis_pkg::MOD_W-1] ? dbl_red + {1'b0, b_ff} : dbl_red;
      acc_in  = (add >= {1'b0, mod_ff}) ? add - {1'b0, mod_ff} : add;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(dis_pkg::MOD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= op_a;
         b_ff   <= op_b;
         mod_ff <= modulus;
         acc_ff <= '0;
      end else if (busy_ff) begin
         a_ff   <= {a_ff[dis_pkg::MOD_W-2:0], 1'b0};
         acc_ff <= acc_in[dis_pkg::MOD_W-1:0];
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

### sv/diagonal_index_set_generator.sv
// Top level of the diagonal index set generator.
// Depends on dis_pkg, dis_cell, dis_divider and dis_modmul.
`default_nettype none
// For each input word with position i the block returns one result word with
// r = ((i mod k)-i)*t*m + ((i mod l)-i)*s*n reduced into 0..n*m-1, where s and
// t are Bezout coefficients of n and m. A word with restart set first clears
// the stored set, checks every dimension against 1..2^DIM_BITS, runs extended
// Euclid on n and m and plain Euclid on k and l, and reduces s, t, m and n
// modulo n*m. Any configuration write invalidates that setup, and until the
// next restart every word reports not_coprime with all other fields zero but
// set_size. The distinct values of r live in a chain of MAX_INDICES cells that
// rotates once around per word to check membership. Each word runs four
// divisions and four modular multiplies; a restart word adds a dimension
// check, the Euclid divisions and gcd tests, and four reductions. The cost
// is set by the bit-serial divider and modular multiplier, both shared, and
// by the one-entry-per-cycle rotation of the chain. One word is worked on at
// a time; a finished result waits in the output register while the next word
// is already accepted. Configuration writes are taken at any time but must
// only be issued while the block is idle.
module diagonal_index_set_generator #(
   parameter int unsigned MAX_INDICES = 256,
   parameter int unsigned DIM_BITS    = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input words. tdata: position[23:0]. tuser: restart.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,
   input  wire logic        req_tuser,
   // Result words. tdata: diag_index[23:0], is_new[24], store_full[25],
   // not_coprime[26], set_size[35:27], zero fill[39:36].
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,
   // Register writes.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [12:0] csr_data
);
   localparam int unsigned CNT_W = $clog2(MAX_INDICES + 1);
   localparam int unsigned LIM_W = 18;
   localparam int unsigned MW    = dis_pkg::MOD_W;
   localparam int unsigned CW    = dis_pkg::COEF_W;

   dis_pkg::state_type state_ff, state_in;

   // Configuration.
   logic [dis_pkg::REG_W-1:0] n_ff, m_ff, k_ff, l_ff;
   logic                      pair_ok_ff;

   // Setup datapath.
   logic [MW-1:0]        a_ff, b_ff;
   logic signed [CW-1:0] ps_ff, s_ff, pt_ff, t_ff;
   logic                 phase_ff;
   logic [MW-1:0]        nm_ff, tr_ff, sr_ff, mr_ff, nr_ff;
   logic [dis_pkg::STEP_W-1:0] step_ff;

   // Item datapath.
   logic [dis_pkg::POS_W-1:0] pos_ff;
   logic [MW-1:0]             x_ff, v1_ff, v2_ff, r_ff;
   logic [CNT_W-1:0]          count_ff, scan_ff;
   logic                      found_ff, fresh_ff, full_ff;

   // Output register.
   logic                      rsp_valid_ff;
   logic [39:0]               rsp_data_ff;

   // Shared units.
   logic          div_start, div_done;
   logic [MW-1:0] div_dividend, div_divisor, div_quot, div_rem;
   logic          mul_start, mul_done;
   logic [MW-1:0] mul_a, mul_b, mul_prod;

   // Chain control.
   logic          chain_shift, chain_rotate;
   logic [MW-1:0] chain_q [MAX_INDICES];
   logic [MW-1:0] head_d;

   logic req_fire, rsp_free, dims_ok, scan_valid, insert_ok;
   logic [MW-1:0] abs_s, abs_t, sum_raw, sum_red, neg_rem;
   logic signed [15:0] q_s;
   logic signed [31:0] s_prod, t_prod;
   logic signed [CW-1:0] s_upd, t_upd;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == dis_pkg::ST_IDLE);

   // A dimension is usable when it lies in 1..2^DIM_BITS.
   assign dims_ok =
      (n_ff != '0) && (LIM_W'(n_ff) <= (LIM_W'(1) << DIM_BITS)) &&
      (m_ff != '0) && (LIM_W'(m_ff) <= (LIM_W'(1) << DIM_BITS)) &&
      (k_ff != '0) && (LIM_W'(k_ff) <= (LIM_W'(1) << DIM_BITS)) &&
      (l_ff != '0) && (LIM_W'(l_ff) <= (LIM_W'(1) << DIM_BITS));

   // Euclid coefficient update: new = prev - q*cur.
   always_comb begin
      q_s    = {2'b00, div_quot[CW-1:0]};
      s_prod = 32'(q_s) * 32'(s_ff);
      t_prod = 32'(q_s) * 32'(t_ff);
      s_upd  = CW'(32'(ps_ff) - s_prod);
      t_upd  = CW'(32'(pt_ff) - t_prod);
      abs_s  = ps_ff[CW-1] ? MW'(-33'(ps_ff)) : MW'(ps_ff);
      abs_t  = pt_ff[CW-1] ? MW'(-33'(pt_ff)) : MW'(pt_ff);
      neg_rem = (div_rem == '0) ? '0 : nm_ff - div_rem;
      sum_raw = v1_ff + v2_ff;
      sum_red = (sum_raw >= nm_ff) ? sum_raw - nm_ff : sum_raw;
   end

   // The cell at the tail holds the entry that was at position
   // MAX_INDICES-1-scan before the rotation began.
   assign scan_valid = ({1'b0, scan_ff} + {1'b0, count_ff}) >= (CNT_W + 1)'(MAX_INDICES);
   assign insert_ok  = !found_ff && (count_ff < CNT_W'(MAX_INDICES));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dis_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser)       state_in = dis_pkg::ST_CHECK;
               else if (pair_ok_ff) state_in = dis_pkg::ST_DIV;
               else                 state_in = dis_pkg::ST_DONE;
            end
         end
         dis_pkg::ST_CHECK: begin
            state_in = dims_ok ? dis_pkg::ST_GCD : dis_pkg::ST_DONE;
         end
         dis_pkg::ST_GCD: begin
            if (b_ff != '0)                  state_in = dis_pkg::ST_GCD_WAIT;
            else if (a_ff != MW'(1))         state_in = dis_pkg::ST_DONE;
            else if (phase_ff)               state_in = dis_pkg::ST_PRE;
            else                             state_in = dis_pkg::ST_GCD;
         end
         dis_pkg::ST_GCD_WAIT: begin
            if (div_done) state_in = dis_pkg::ST_GCD;
         end
         dis_pkg::ST_PRE:  state_in = dis_pkg::ST_PRE_WAIT;
         dis_pkg::ST_PRE_WAIT: begin
            if (div_done) begin
               state_in = (step_ff == dis_pkg::STEP_LAST) ? dis_pkg::ST_DIV : dis_pkg::ST_PRE;
            end
         end
         dis_pkg::ST_DIV:  state_in = dis_pkg::ST_DIV_WAIT;
         dis_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = (step_ff == dis_pkg::STEP_LAST) ? dis_pkg::ST_MUL : dis_pkg::ST_DIV;
            end
         end
         dis_pkg::ST_MUL:  state_in = dis_pkg::ST_MUL_WAIT;
         dis_pkg::ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = (step_ff == dis_pkg::STEP_LAST) ? dis_pkg::ST_SUM : dis_pkg::ST_MUL;
            end
         end
         dis_pkg::ST_SUM:  state_in = dis_pkg::ST_SEARCH;
         dis_pkg::ST_SEARCH: begin
            if (scan_ff == CNT_W'(MAX_INDICES - 1)) state_in = dis_pkg::ST_INSERT;
         end
         dis_pkg::ST_INSERT: state_in = dis_pkg::ST_DONE;
         dis_pkg::ST_DONE: begin
            if (rsp_free) state_in = dis_pkg::ST_IDLE;
         end
         default: state_in = dis_pkg::ST_IDLE;
      endcase
   end

   // Unit and chain controls.
   always_comb begin
      div_start    = 1'b0;
      div_dividend = a_ff;
      div_divisor  = b_ff;
      mul_start    = 1'b0;
      mul_a        = v1_ff;
      mul_b        = tr_ff;
      chain_rotate = 1'b0;
      chain_shift  = 1'b0;
      unique case (state_ff)
         dis_pkg::ST_GCD: begin
            div_start = (b_ff != '0);
         end
         dis_pkg::ST_PRE: begin
            div_start   = 1'b1;
            div_divisor = nm_ff;
            unique case (step_ff)
               dis_pkg::STEP_FIRST:  div_dividend = abs_t;
               dis_pkg::STEP_SECOND: div_dividend = abs_s;
               dis_pkg::STEP_THIRD:  div_dividend = MW'(m_ff);
               dis_pkg::STEP_LAST:   div_dividend = MW'(n_ff);
               default:              div_dividend = MW'(n_ff);
            endcase
         end
         dis_pkg::ST_DIV: begin
            div_start = 1'b1;
            unique case (step_ff)
               dis_pkg::STEP_FIRST: begin
                  div_dividend = MW'(pos_ff);
                  div_divisor  = MW'(k_ff);
               end
               dis_pkg::STEP_THIRD: begin
                  div_dividend = MW'(pos_ff);
                  div_divisor  = MW'(l_ff);
               end
               default: begin
                  div_dividend = x_ff;
                  div_divisor  = nm_ff;
               end
            endcase
         end
         dis_pkg::ST_MUL: begin
            mul_start = 1'b1;
            unique case (step_ff)
               dis_pkg::STEP_FIRST: begin
                  mul_a = v1_ff;
                  mul_b = tr_ff;
               end
               dis_pkg::STEP_SECOND: begin
                  mul_a = v1_ff;
                  mul_b = mr_ff;
               end
               dis_pkg::STEP_THIRD: begin
                  mul_a = v2_ff;
                  mul_b = sr_ff;
               end
               default: begin
                  mul_a = v2_ff;
                  mul_b = nr_ff;
               end
            endcase
         end
         dis_pkg::ST_SEARCH: begin
            chain_rotate = 1'b1;
            chain_shift  = 1'b1;
         end
         dis_pkg::ST_INSERT: begin
            chain_shift = insert_ok;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dis_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= dis_pkg::REG_W'(1);
         m_ff         <= dis_pkg::REG_W'(1);
         k_ff         <= dis_pkg::REG_W'(1);
         l_ff         <= dis_pkg::REG_W'(1);
         pair_ok_ff   <= 1'b0;
         count_ff     <= '0;
         step_ff      <= dis_pkg::STEP_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            pair_ok_ff <= 1'b0;
            unique case (csr_index)
               dis_pkg::REG_ROWS_TOTAL: n_ff <= csr_data;
               dis_pkg::REG_COLS_TOTAL: m_ff <= csr_data;
               dis_pkg::REG_SUB_ROWS:   k_ff <= csr_data;
               dis_pkg::REG_SUB_COLS:   l_ff <= csr_data;
               default:                 l_ff <= csr_data;
            endcase
         end
         if (req_fire && req_tuser) begin
            count_ff   <= '0;
            pair_ok_ff <= 1'b0;
         end
         if (state_ff == dis_pkg::ST_GCD && b_ff == '0 && a_ff == MW'(1) && phase_ff) begin
            pair_ok_ff <= 1'b1;
         end
         if ((state_ff == dis_pkg::ST_PRE_WAIT || state_ff == dis_pkg::ST_DIV_WAIT) && div_done) begin
            step_ff <= step_ff + 1'b1;
         end
         if (state_ff == dis_pkg::ST_MUL_WAIT && mul_done) begin
            step_ff <= step_ff + 1'b1;
         end
         if (state_ff == dis_pkg::ST_INSERT && insert_ok) begin
            count_ff <= count_ff + 1'b1;
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == dis_pkg::ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pos_ff <= req_tdata;
      end
      unique case (state_ff)
         dis_pkg::ST_CHECK: begin
            a_ff     <= MW'(n_ff);
            b_ff     <= MW'(m_ff);
            ps_ff    <= CW'(1);
            s_ff     <= '0;
            pt_ff    <= '0;
            t_ff     <= CW'(1);
            phase_ff <= 1'b0;
            nm_ff    <= MW'(n_ff) * MW'(m_ff);
         end
         dis_pkg::ST_GCD: begin
            if (b_ff == '0 && a_ff == MW'(1) && !phase_ff) begin
               a_ff     <= MW'(k_ff);
               b_ff     <= MW'(l_ff);
               phase_ff <= 1'b1;
            end
         end
         dis_pkg::ST_GCD_WAIT: begin
            if (div_done) begin
               a_ff <= b_ff;
               b_ff <= div_rem;
               if (!phase_ff) begin
                  ps_ff <= s_ff;
                  s_ff  <= s_upd;
                  pt_ff <= t_ff;
                  t_ff  <= t_upd;
               end
            end
         end
         dis_pkg::ST_PRE_WAIT: begin
            if (div_done) begin
               unique case (step_ff)
                  dis_pkg::STEP_FIRST:  tr_ff <= pt_ff[CW-1] ? neg_rem : div_rem;
                  dis_pkg::STEP_SECOND: sr_ff <= ps_ff[CW-1] ? neg_rem : div_rem;
                  dis_pkg::STEP_THIRD:  mr_ff <= div_rem;
                  default:              nr_ff <= div_rem;
               endcase
            end
         end
         dis_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               unique case (step_ff)
                  dis_pkg::STEP_FIRST:  x_ff  <= MW'(pos_ff) - div_rem;
                  dis_pkg::STEP_SECOND: v1_ff <= neg_rem;
                  dis_pkg::STEP_THIRD:  x_ff  <= MW'(pos_ff) - div_rem;
                  default:              v2_ff <= neg_rem;
               endcase
            end
         end
         dis_pkg::ST_MUL_WAIT: begin
            if (mul_done) begin
               if (step_ff == dis_pkg::STEP_FIRST || step_ff == dis_pkg::STEP_SECOND) begin
                  v1_ff <= mul_prod;
               end else begin
                  v2_ff <= mul_prod;
               end
            end
         end
         dis_pkg::ST_SUM: begin
            r_ff     <= sum_red;
            scan_ff  <= '0;
            found_ff <= 1'b0;
         end
         dis_pkg::ST_SEARCH: begin
            scan_ff <= scan_ff + 1'b1;
            if (scan_valid && chain_q[MAX_INDICES-1] == r_ff) begin
               found_ff <= 1'b1;
            end
         end
         dis_pkg::ST_INSERT: begin
            fresh_ff <= !found_ff;
            full_ff  <= !found_ff && (count_ff == CNT_W'(MAX_INDICES));
         end
         default: begin
         end
      endcase
      if (state_ff == dis_pkg::ST_DONE && rsp_free) begin
         rsp_data_ff <= {4'b0000,
                         dis_pkg::SIZE_W'(count_ff),
                         !pair_ok_ff,
                         pair_ok_ff && full_ff,
                         pair_ok_ff && fresh_ff,
                         pair_ok_ff ? r_ff[dis_pkg::POS_W-1:0] : dis_pkg::POS_W'(0)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   dis_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   dis_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (nm_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   // The chain rotates once around during a search and takes a new entry at
   // its head on an insert; valid entries always sit in cells 0..count-1.
   assign head_d = chain_rotate ? chain_q[MAX_INDICES-1] : r_ff;

   for (genvar j = 0; j < MAX_INDICES; j++) begin : g_chain
      if (j == 0) begin : g_head
         dis_cell #(.WIDTH(MW)) u_cell (
            .clock    (clock),
            .shift_en (chain_shift),
            .d        (head_d),
            .q        (chain_q[j])
         );
      end else begin : g_body
         dis_cell #(.WIDTH(MW)) u_cell (
            .clock    (clock),
            .shift_en (chain_shift),
            .d        (chain_q[j-1]),
            .q        (chain_q[j])
         );
      end
   end
endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench of the diagonal index set generator.
// Depends on dis_pkg and diagonal_index_set_generator; stands alone.
`default_nettype none
module tb;

   localparam int unsigned MAX_SET   = 256;
   localparam int unsigned DIM_LIMIT = 4096;
   localparam int unsigned CYCLE_CAP = 10000000;

   // One input word as the driver holds it.
   typedef struct {
      logic [23:0] position;
      logic        restart;
   } index_word_type;

   // One result word, unpacked.
   typedef struct {
      logic [23:0] diag_index;
      logic        is_new;
      logic        store_full;
      logic        not_coprime;
      logic [8:0]  set_size;
   } diag_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [12:0] csr_data;

   diagonal_index_set_generator DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Words waiting to be sent and results waiting to arrive.
   index_word_type pending_words[$];
   diag_word_type  expected_diags[$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   // Shadow of the block's state: dimension registers, Bezout pair and the set.
   logic [12:0] dims[4];
   longint      coef_s, coef_t;
   bit          setup_valid;
   logic [23:0] seen_set[MAX_SET];
   int unsigned seen_total;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic longint gcd_of(input longint a, input longint b);
      longint r;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      return a;
   endfunction

   // Extended Euclid on positive operands; coefficients returned through ca, cb.
   function automatic longint bezout_split(input longint a, input longint b,
                                          output longint ca, output longint cb);
      longint ps, s, pt, t, q, r, tmp;
      ps = 1; s = 0; pt = 0; t = 1;
      while (b != 0) begin
         q = a / b;
         r = a % b;
         a = b;
         b = r;
         tmp = s; s = ps - q * s; ps = tmp;
         tmp = t; t = pt - q * t; pt = tmp;
      end
      ca = ps;
      cb = pt;
      return a;
   endfunction

   function automatic longint residue_of(input longint v, input longint modulus);
      longint r;
      r = v % modulus;
      return (r < 0) ? r + modulus : r;
   endfunction

   // ((i mod d) - i) * coef * mult, brought into 0..modulus-1.
   function automatic longint partial_term(input longint i, input longint d,
                                          input longint coef, input longint mult,
                                          input longint modulus);
      longint a, v;
      a = (i - i % d) % modulus;
      v = (modulus - a) % modulus;
      v = (v * residue_of(coef, modulus)) % modulus;
      v = (v * (mult % modulus)) % modulus;
      return v;
   endfunction

   function automatic void redo_setup();
      longint cs, ct, g;
      bit ok;
      ok = 1'b1;
      cs = 0;
      ct = 0;
      for (int j = 0; j < 4; j++)
         if (dims[j] == 0 || dims[j] > DIM_LIMIT) ok = 1'b0;
      if (ok) begin
         g = bezout_split(dims[dis_pkg::REG_ROWS_TOTAL], dims[dis_pkg::REG_COLS_TOTAL],
                          cs, ct);
         ok = (g == 1) &&
              (gcd_of(dims[dis_pkg::REG_SUB_ROWS], dims[dis_pkg::REG_SUB_COLS]) == 1);
      end
      setup_valid = ok;
      coef_s = ok ? cs : 0;
      coef_t = ok ? ct : 0;
   endfunction

   // Advances the shadow state by one accepted word and returns its result.
   function automatic diag_word_type predict_diag(input index_word_type w);
      diag_word_type d;
      longint n, m, modulus, r;
      bit fresh;
      d = '{default: '0};
      if (w.restart) begin
         seen_total = 0;
         redo_setup();
      end
      if (setup_valid) begin
         n = dims[dis_pkg::REG_ROWS_TOTAL];
         m = dims[dis_pkg::REG_COLS_TOTAL];
         modulus = n * m;
         r = (partial_term(w.position, dims[dis_pkg::REG_SUB_ROWS], coef_t, m, modulus) +
              partial_term(w.position, dims[dis_pkg::REG_SUB_COLS], coef_s, n, modulus))
             % modulus;
         fresh = 1'b1;
         for (int j = 0; j < seen_total; j++)
            if (seen_set[j] == r[23:0]) fresh = 1'b0;
         if (fresh) begin
            if (seen_total < MAX_SET) begin
               seen_set[seen_total] = r[23:0];
               seen_total++;
            end else begin
               d.store_full = 1'b1;
            end
         end
         d.diag_index = r[23:0];
         d.is_new = fresh;
      end
      d.not_coprime = !setup_valid;
      d.set_size = seen_total[8:0];
      return d;
   endfunction

   // Gap lengths: mostly none or short, now and then long; some stretches run flat out.
   function automatic int unsigned pick_gap(input bit flat_out);
      int unsigned roll;
      roll = $urandom_range(99);
      if (flat_out || roll < 55) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(60, 15);
   endfunction

   // Driver: presents the next queued word once the current one is taken.
   int unsigned    send_gap = 0;
   bit             send_flat = 1'b0;
   index_word_type on_bus;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_diags = {expected_diags, predict_diag(on_bus)};
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               on_bus = pending_words.pop_front();
               req_tdata  <= on_bus.position;
               req_tuser  <= on_bus.restart;
               req_tvalid <= 1'b1;
               if ($urandom_range(49) == 0) send_flat = !send_flat;
               send_gap <= pick_gap(send_flat);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each taken result word against the oldest expectation.
   int unsigned   hold_gap = 0;
   bit            hold_flat = 1'b0;
   diag_word_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_diags.size() == 0) begin
               report_mismatch("result word with no expectation");
            end else begin
               want = expected_diags.pop_front();
               if (rsp_tdata[23:0] !== want.diag_index)
                  report_mismatch($sformatf("diag_index %0d, expected %0d",
                                            rsp_tdata[23:0], want.diag_index));
               if (rsp_tdata[24] !== want.is_new)
                  report_mismatch($sformatf("is_new %b, expected %b",
                                            rsp_tdata[24], want.is_new));
               if (rsp_tdata[25] !== want.store_full)
                  report_mismatch($sformatf("store_full %b, expected %b",
                                            rsp_tdata[25], want.store_full));
               if (rsp_tdata[26] !== want.not_coprime)
                  report_mismatch($sformatf("not_coprime %b, expected %b",
                                            rsp_tdata[26], want.not_coprime));
               if (rsp_tdata[35:27] !== want.set_size)
                  report_mismatch($sformatf("set_size %0d, expected %0d",
                                            rsp_tdata[35:27], want.set_size));
            end
         end
         if (hold_gap > 0) begin
            hold_gap <= hold_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(49) == 0) hold_flat = !hold_flat;
            if (!hold_flat && $urandom_range(3) == 0) hold_gap <= pick_gap(1'b0);
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Waits until every queued word is sent and every result is in, then lets
   // the block settle before a register write. The state is sampled at the
   // falling edge, where the driver's updates have all landed.
   task automatic drain_block();
      while (pending_words.size() != 0 || expected_diags.size() != 0 || req_tvalid)
         @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_dim(input logic [1:0] index, input logic [12:0] value);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      dims[index] = value;
      setup_valid = 1'b0;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_dims(input logic [12:0] n, input logic [12:0] m,
                             input logic [12:0] k, input logic [12:0] l);
      drain_block();
      write_dim(dis_pkg::REG_ROWS_TOTAL, n);
      write_dim(dis_pkg::REG_COLS_TOTAL, m);
      write_dim(dis_pkg::REG_SUB_ROWS, k);
      write_dim(dis_pkg::REG_SUB_COLS, l);
   endtask

   task automatic queue_word(input logic [23:0] position, input logic restart);
      index_word_type w;
      w.position = position;
      w.restart = restart;
      pending_words = {pending_words, w};
   endtask

   // Mostly positions inside 0..k*l-1, some anywhere in the 24-bit range.
   function automatic logic [23:0] pick_position();
      int unsigned span;
      span = dims[dis_pkg::REG_SUB_ROWS] * dims[dis_pkg::REG_SUB_COLS];
      if (span == 0 || span > 24'hFFFFFF || $urandom_range(4) == 0)
         return 24'($urandom_range(24'hFFFFFF));
      return 24'($urandom_range(span - 1));
   endfunction

   function automatic logic [12:0] coprime_partner(input logic [12:0] a);
      logic [12:0] b;
      for (int tries = 0; tries < 20; tries++) begin
         b = 13'($urandom_range(DIM_LIMIT, 1));
         if (gcd_of(a, b) == 1) return b;
      end
      return 13'd1;
   endfunction

   logic [12:0] n_pick, k_pick;
   int unsigned run_len;
   int unsigned sent;

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      for (int j = 0; j < 4; j++) dims[j] = 13'd1;
      coef_s = 0;
      coef_t = 0;
      setup_valid = 1'b0;
      seen_total = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Without any restart since reset every word reports not coprime.
      queue_word(24'd0, 1'b0);
      queue_word(24'hFFFFFF, 1'b0);
      // Reset dimensions of one are a valid setup with a single residue.
      queue_word(24'd3, 1'b1);
      queue_word(24'd7, 1'b0);

      // A small coprime setup, positions at the extremes and beyond k*l.
      write_dims(13'd5, 13'd7, 13'd2, 13'd3);
      queue_word(24'd1, 1'b0);       // written but not restarted yet
      for (int p = 0; p < 6; p++) queue_word(p[23:0], p == 0);
      queue_word(24'd6, 1'b0);
      queue_word(24'hFFFFFF, 1'b0);
      queue_word(24'h800000, 1'b0);

      // Pairs that are not coprime, a zero and an oversized dimension.
      write_dims(13'd4, 13'd6, 13'd2, 13'd3);
      queue_word(24'd5, 1'b1);
      write_dims(13'd3, 13'd5, 13'd2, 13'd4);
      queue_word(24'd5, 1'b1);
      write_dims(13'd0, 13'd5, 13'd2, 13'd3);
      queue_word(24'd5, 1'b1);
      write_dims(13'd4097, 13'd8191, 13'd1, 13'd1);
      queue_word(24'd5, 1'b1);

      // Largest valid dimensions, long enough to fill the store.
      write_dims(13'd4096, 13'd4095, 13'd4096, 13'd4095);
      queue_word(24'd0, 1'b1);
      for (int p = 0; p < 290; p++) queue_word(pick_position(), 1'b0);

      // Random phases, each starting with a register update.
      sent = 0;
      while (sent < 600) begin
         if ($urandom_range(9) == 0) begin
            n_pick = 13'($urandom_range(13'h1FFF));
            write_dims(n_pick, 13'($urandom_range(13'h1FFF)),
                       13'($urandom_range(13'h1FFF)), 13'($urandom_range(13'h1FFF)));
         end else begin
            n_pick = $urandom_range(3) == 0 ? 13'($urandom_range(DIM_LIMIT, 1))
                                            : 13'($urandom_range(64, 1));
            k_pick = $urandom_range(3) == 0 ? 13'($urandom_range(DIM_LIMIT, 1))
                                            : 13'($urandom_range(16, 1));
            write_dims(n_pick, coprime_partner(n_pick), k_pick, coprime_partner(k_pick));
         end
         run_len = $urandom_range(40, 5);
         for (int p = 0; p < run_len; p++)
            queue_word(pick_position(),
                       (p == 0 && $urandom_range(19) != 0) || $urandom_range(29) == 0);
         sent += run_len;
      end

      drain_block();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
